/* rtl/core/adrk_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adrk_pkg
// Shared types and constants of the periodic advection-diffusion RK2 block:
// field widths, command and register codes, shift codes and handshake words.
// ----------------------------------------------------------------------------
package adrk_pkg;

	localparam int MAX_CELLS_DEF  = 256;
	localparam int VALUE_BITS_DEF = 32;
	localparam int MIN_CELLS      = 3;

	localparam int CMD_BITS      = 2;
	localparam int INDEX_BITS    = 8;
	localparam int FIELD_BITS    = 32;
	localparam int DT_BITS       = 32;
	localparam int COUNT_BITS    = 9;
	localparam int ADV_BITS      = 32;
	localparam int COEF_BITS     = 48;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 48;
	localparam int DIGIT_BITS    = 16;

	localparam logic [CMD_BITS-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_STEP  = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_READ  = 2'd2;

	localparam logic [CFG_IDX_BITS-1:0] REG_CELL_COUNT = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_ADV_COEF   = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_DIFF_COEF  = 2'd2;

	localparam logic [COUNT_BITS-1:0] CELL_COUNT_RST = 9'd256;
	localparam logic [ADV_BITS-1:0]   ADV_COEF_RST   = 32'd4194304;
	localparam logic [COEF_BITS-1:0]  DIFF_COEF_RST  = 48'd65536;

	typedef enum logic [1:0] {
		SH_16,
		SH_32,
		SH_33
	} adrk_shift_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0] cell_count;
		logic [ADV_BITS-1:0]   adv;
		logic [COEF_BITS-1:0]  diff;
	} adrk_cfg_t;

	typedef struct packed {
		logic [CMD_BITS-1:0]   cmd;
		logic [INDEX_BITS-1:0] index;
		logic [FIELD_BITS-1:0] value;
		logic [DT_BITS-1:0]    dt;
	} adrk_cmd_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] read_value;
		logic                  saturated;
	} adrk_res_t;

endpackage

/* rtl/core/adrk_mulsh.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adrk_mulsh
// Iterative sign-magnitude multiplier with floor shift and saturation.
// One 48x16 partial product per cycle, msb digit first; a final state then
// shifts, rounds toward minus infinity and clips to the value range.
// ----------------------------------------------------------------------------
module adrk_mulsh #(
	parameter int VALUE_BITS = adrk_pkg::VALUE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            go,
	input  adrk_pkg::adrk_shift_t           shift,
	input  logic [adrk_pkg::COEF_BITS-1:0]  a_mag,
	input  logic                            a_neg,
	input  logic [VALUE_BITS+1:0]           b,
	output logic                            done,
	output logic                            ovf,
	output logic [VALUE_BITS-1:0]           res
);

	localparam int W    = VALUE_BITS;
	localparam int BB   = W + 1;
	localparam int DB   = adrk_pkg::DIGIT_BITS;
	localparam int ND   = (BB + DB - 1) / DB;
	localparam int BPAD = ND * DB;
	localparam int AB   = adrk_pkg::COEF_BITS;
	localparam int PW   = AB + BPAD;
	localparam int CW   = (ND > 1) ? $clog2(ND) : 1;

	localparam logic [1:0] M_IDLE = 2'd0;
	localparam logic [1:0] M_RUN  = 2'd1;
	localparam logic [1:0] M_FIN  = 2'd2;

	localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

	logic [1:0]                  state_q;
	logic [CW-1:0]               cnt_q;
	logic                        done_q;
	logic [AB-1:0]               a_q;
	logic [BPAD-1:0]             bm_q;
	logic [PW-1:0]               acc_q;
	logic                        neg_q;
	adrk_pkg::adrk_shift_t       sh_q;
	logic [W-1:0]                res_q;
	logic                        ovf_q;

	logic [W+1:0]                b_abs;
	logic [AB+DB-1:0]            pp;
	logic [PW-1:0]               q;
	logic [PW-1:0]               c;
	logic                        rem;
	logic                        ovf_pos;
	logic                        ovf_neg;
	logic [W-1:0]                fin_val;

	assign b_abs = b[W+1] ? ((W+2)'(0) - b) : b;
	assign pp    = a_q * bm_q[BPAD-1 -: DB];

	always_comb begin
		unique case (sh_q)
			adrk_pkg::SH_16: begin
				q   = acc_q >> 16;
				rem = |acc_q[15:0];
			end
			adrk_pkg::SH_32: begin
				q   = acc_q >> 32;
				rem = |acc_q[31:0];
			end
			adrk_pkg::SH_33: begin
				q   = acc_q >> 33;
				rem = |acc_q[32:0];
			end
			default: begin
				q   = acc_q >> 16;
				rem = |acc_q[15:0];
			end
		endcase
		c       = q + PW'(rem);
		ovf_pos = |q[PW-1:W-1];
		ovf_neg = (|c[PW-1:W]) || (c[W-1] && (|c[W-2:0]));
		if (neg_q) begin
			fin_val = ovf_neg ? VMIN : (W'(0) - c[W-1:0]);
		end else begin
			fin_val = ovf_pos ? VMAX : q[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == M_FIN);
			unique case (state_q)
				M_IDLE: begin
					if (go) begin
						state_q <= M_RUN;
						cnt_q   <= '0;
					end
				end
				M_RUN: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(ND - 1)) begin
						state_q <= M_FIN;
					end
				end
				M_FIN: begin
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == M_IDLE && go) begin
			a_q   <= a_mag;
			bm_q  <= BPAD'(b_abs[W:0]);
			neg_q <= a_neg ^ b[W+1];
			sh_q  <= shift;
			acc_q <= '0;
		end else if (state_q == M_RUN) begin
			acc_q <= (acc_q << DB) + PW'(pp);
			bm_q  <= bm_q << DB;
		end
		if (state_q == M_FIN) begin
			res_q <= fin_val;
			ovf_q <= neg_q ? ovf_neg : ovf_pos;
		end
	end

	assign done = done_q;
	assign ovf  = ovf_q;
	assign res  = res_q;

endmodule

/* rtl/core/adrk_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adrk_core
// Grid memories and the command sequencer. Writes and reads go straight to
// the value memory; an advance makes two passes over the ring with a
// three-value window, sharing one multiplier for every product.
// ----------------------------------------------------------------------------
module adrk_core #(
	parameter int MAX_CELLS  = adrk_pkg::MAX_CELLS_DEF,
	parameter int VALUE_BITS = adrk_pkg::VALUE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  adrk_pkg::adrk_cfg_t cfg,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  adrk_pkg::adrk_cmd_t cmd,
	output logic                res_valid,
	input  logic                res_ready,
	output adrk_pkg::adrk_res_t res
);

	localparam int W  = VALUE_BITS;
	localparam int WB = W + 2;
	localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int NW = AW + 1;
	localparam int FB = adrk_pkg::FIELD_BITS;

	localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [63:0] VMAX_X = (64'sd1 <<< (W - 1)) - 64'sd1;
	localparam logic signed [63:0] VMIN_X = -VMAX_X - 64'sd1;
	localparam logic signed [63:0] FMAX_X = 64'sh7FFF_FFFF;
	localparam logic signed [63:0] FMIN_X = -FMAX_X - 64'sd1;

	localparam logic [3:0] S_CLEAR  = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_RD     = 4'd2;
	localparam logic [3:0] S_RESULT = 4'd3;
	localparam logic [3:0] S_PRIME0 = 4'd4;
	localparam logic [3:0] S_PRIME1 = 4'd5;
	localparam logic [3:0] S_PRIME2 = 4'd6;
	localparam logic [3:0] S_SHIFT  = 4'd7;
	localparam logic [3:0] S_TA     = 4'd8;
	localparam logic [3:0] S_TA_W   = 4'd9;
	localparam logic [3:0] S_TD_W   = 4'd10;
	localparam logic [3:0] S_SUM    = 4'd11;
	localparam logic [3:0] S_ST     = 4'd12;
	localparam logic [3:0] S_ST_W   = 4'd13;
	localparam logic [3:0] S_UPD    = 4'd14;

	// memories
	logic [W-1:0] cell_mem  [MAX_CELLS];
	logic [W-1:0] stage_mem [MAX_CELLS];
	logic [W-1:0] k1_mem    [MAX_CELLS];

	logic          cell_we;
	logic [AW-1:0] cell_waddr;
	logic [W-1:0]  cell_wdata;
	logic [AW-1:0] cell_raddr;
	logic [W-1:0]  cell_rdata;
	logic          stage_we;
	logic [AW-1:0] stage_raddr;
	logic [W-1:0]  stage_rdata;
	logic          k1_we;
	logic [AW-1:0] k1_raddr;
	logic [W-1:0]  k1_rdata;

	// control
	logic [3:0]    state_q;
	logic [3:0]    state_d;
	logic [AW-1:0] clr_q;
	logic          ovf_q;
	logic          pass_q;
	logic [AW-1:0] ptr_q;

	// payload
	logic [NW-1:0] n_q;
	logic [adrk_pkg::DT_BITS-1:0] dt_q;
	logic [FB-1:0] rv_q;
	logic [W-1:0]  win_l_q;
	logic [W-1:0]  win_m_q;
	logic [W-1:0]  win_r_q;
	logic [W-1:0]  cell_i_q;
	logic [W-1:0]  k1_q;
	logic [W-1:0]  ta_q;
	logic [W-1:0]  td_q;
	logic [W-1:0]  slope_q;
	logic [W-1:0]  inc_q;

	logic          accept;
	logic          in_rng;
	logic          wr_clip;
	logic [W-1:0]  wr_val;
	logic signed [63:0] wv_x;
	logic signed [63:0] rd_x;
	logic [FB-1:0] rd_clamp;
	logic [NW-1:0] ring_n;
	logic          last;
	logic [AW-1:0] nx;
	logic [AW-1:0] rnx;
	logic [AW-1:0] win_addr;
	logic [WB-1:0] lx;
	logic [WB-1:0] mx;
	logic [WB-1:0] rx;
	logic [WB-1:0] d1;
	logic [WB-1:0] d2;
	logic [WB-1:0] k1x;
	logic [WB-1:0] k12;
	logic [W:0]    s_sum;
	logic          s_ovf;
	logic [W-1:0]  s_sat;
	logic [W-1:0]  base;
	logic [W:0]    u_sum;
	logic          u_ovf;
	logic [W-1:0]  u_sat;
	logic [32:0]   adv_x;
	logic [32:0]   adv_abs;
	logic          set_ovf;

	logic                            mul_go;
	adrk_pkg::adrk_shift_t           mul_sh;
	logic [adrk_pkg::COEF_BITS-1:0]  mul_a;
	logic                            mul_a_neg;
	logic [WB-1:0]                   mul_b;
	logic                            mul_done;
	logic                            mul_ovf;
	logic [W-1:0]                    mul_res;

	adrk_mulsh #(
		.VALUE_BITS(VALUE_BITS)
	) u_mulsh (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (mul_go),
		.shift (mul_sh),
		.a_mag (mul_a),
		.a_neg (mul_a_neg),
		.b     (mul_b),
		.done  (mul_done),
		.ovf   (mul_ovf),
		.res   (mul_res)
	);

	assign cmd_ready = (state_q == S_IDLE);
	assign accept    = cmd_valid && cmd_ready;
	assign res_valid = (state_q == S_RESULT);
	assign res       = '{read_value: rv_q, saturated: ovf_q};

	assign in_rng  = ({24'b0, cmd.index} < 32'(MAX_CELLS));
	assign wv_x    = 64'($signed(cmd.value));
	assign wr_clip = (wv_x > VMAX_X) || (wv_x < VMIN_X);
	assign wr_val  = (wv_x > VMAX_X) ? VMAX : ((wv_x < VMIN_X) ? VMIN : W'(wv_x));

	assign rd_x     = 64'($signed(cell_rdata));
	assign rd_clamp = (rd_x > FMAX_X) ? FB'(FMAX_X) : ((rd_x < FMIN_X) ? FB'(FMIN_X) : FB'(rd_x));

	assign ring_n = (cfg.cell_count < adrk_pkg::COUNT_BITS'(adrk_pkg::MIN_CELLS)) ?
		NW'(adrk_pkg::MIN_CELLS) :
		((32'(cfg.cell_count) > 32'(MAX_CELLS)) ? NW'(MAX_CELLS) : NW'(cfg.cell_count));

	assign last = (({1'b0, ptr_q} + NW'(1)) == n_q);
	assign nx   = (state_q == S_PRIME2) ? '0 : (ptr_q + AW'(1));
	assign rnx  = (({1'b0, nx} + NW'(1)) == n_q) ? '0 : (nx + AW'(1));

	always_comb begin
		unique case (state_q)
			S_PRIME0: win_addr = AW'(n_q - NW'(1));
			S_PRIME1: win_addr = '0;
			default:  win_addr = rnx;
		endcase
	end

	// window arithmetic
	assign lx  = {{2{win_l_q[W-1]}}, win_l_q};
	assign mx  = {{2{win_m_q[W-1]}}, win_m_q};
	assign rx  = {{2{win_r_q[W-1]}}, win_r_q};
	assign d1  = lx - rx;
	assign d2  = rx + lx - {mx[WB-2:0], 1'b0};
	assign k1x = {{2{slope_q[W-1]}}, slope_q};
	assign k12 = k1x + {{2{k1_q[W-1]}}, k1_q};

	assign s_sum = {ta_q[W-1], ta_q} + {td_q[W-1], td_q};
	assign s_ovf = s_sum[W] != s_sum[W-1];
	assign s_sat = s_ovf ? (s_sum[W] ? VMIN : VMAX) : s_sum[W-1:0];

	assign base  = pass_q ? cell_i_q : win_m_q;
	assign u_sum = {base[W-1], base} + {inc_q[W-1], inc_q};
	assign u_ovf = u_sum[W] != u_sum[W-1];
	assign u_sat = u_ovf ? (u_sum[W] ? VMIN : VMAX) : u_sum[W-1:0];

	assign adv_x   = {cfg.adv[adrk_pkg::ADV_BITS-1], cfg.adv};
	assign adv_abs = cfg.adv[adrk_pkg::ADV_BITS-1] ? (33'd0 - adv_x) : adv_x;

	// multiplier requests
	always_comb begin
		mul_go    = 1'b0;
		mul_sh    = adrk_pkg::SH_16;
		mul_a     = adrk_pkg::COEF_BITS'(adv_abs);
		mul_a_neg = cfg.adv[adrk_pkg::ADV_BITS-1];
		mul_b     = d1;
		unique case (state_q)
			S_TA: begin
				mul_go = 1'b1;
			end
			S_TA_W: begin
				mul_go    = mul_done;
				mul_a     = cfg.diff;
				mul_a_neg = 1'b0;
				mul_b     = d2;
			end
			S_ST: begin
				mul_go    = 1'b1;
				mul_sh    = pass_q ? adrk_pkg::SH_33 : adrk_pkg::SH_32;
				mul_a     = adrk_pkg::COEF_BITS'(dt_q);
				mul_a_neg = 1'b0;
				mul_b     = pass_q ? k12 : k1x;
			end
			default: begin
				mul_go = 1'b0;
			end
		endcase
	end

	// memory ports
	always_comb begin
		cell_we    = 1'b0;
		cell_waddr = ptr_q;
		cell_wdata = u_sat;
		stage_we   = (state_q == S_UPD) && !pass_q;
		k1_we      = (state_q == S_SUM) && !pass_q;
		if (state_q == S_CLEAR) begin
			cell_we    = 1'b1;
			cell_waddr = clr_q;
			cell_wdata = '0;
		end else if (accept && cmd.cmd == adrk_pkg::CMD_WRITE) begin
			cell_we    = in_rng;
			cell_waddr = AW'(cmd.index);
			cell_wdata = wr_val;
		end else if (state_q == S_UPD && pass_q) begin
			cell_we = 1'b1;
		end
		if (state_q == S_IDLE) begin
			cell_raddr = AW'(cmd.index);
		end else begin
			cell_raddr = pass_q ? nx : win_addr;
		end
		stage_raddr = win_addr;
		k1_raddr    = nx;
	end

	always_ff @(posedge clk) begin
		if (cell_we) begin
			cell_mem[cell_waddr] <= cell_wdata;
		end
		cell_rdata <= cell_mem[cell_raddr];
	end

	always_ff @(posedge clk) begin
		if (stage_we) begin
			stage_mem[ptr_q] <= u_sat;
		end
		stage_rdata <= stage_mem[stage_raddr];
	end

	always_ff @(posedge clk) begin
		if (k1_we) begin
			k1_mem[ptr_q] <= s_sat;
		end
		k1_rdata <= k1_mem[k1_raddr];
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR:  if (clr_q == AW'(MAX_CELLS - 1)) state_d = S_IDLE;
			S_IDLE: begin
				if (accept) begin
					unique case (cmd.cmd)
						adrk_pkg::CMD_STEP: state_d = S_PRIME0;
						adrk_pkg::CMD_READ: state_d = in_rng ? S_RD : S_RESULT;
						default:            state_d = S_RESULT;
					endcase
				end
			end
			S_RD:     state_d = S_RESULT;
			S_RESULT: if (res_ready) state_d = S_IDLE;
			S_PRIME0: state_d = S_PRIME1;
			S_PRIME1: state_d = S_PRIME2;
			S_PRIME2: state_d = S_SHIFT;
			S_SHIFT:  state_d = S_TA;
			S_TA:     state_d = S_TA_W;
			S_TA_W:   if (mul_done) state_d = S_TD_W;
			S_TD_W:   if (mul_done) state_d = S_SUM;
			S_SUM:    state_d = S_ST;
			S_ST:     state_d = S_ST_W;
			S_ST_W:   if (mul_done) state_d = S_UPD;
			S_UPD: begin
				if (!last) begin
					state_d = S_SHIFT;
				end else begin
					state_d = pass_q ? S_RESULT : S_PRIME0;
				end
			end
			default:  state_d = S_IDLE;
		endcase
	end

	assign set_ovf = (mul_done && mul_ovf) ||
		(state_q == S_SUM && s_ovf) ||
		(state_q == S_UPD && u_ovf) ||
		(accept && cmd.cmd == adrk_pkg::CMD_WRITE && in_rng && wr_clip);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			ovf_q   <= 1'b0;
			pass_q  <= 1'b0;
			ptr_q   <= '0;
		end else begin
			state_q <= state_d;
			ovf_q   <= ovf_q | set_ovf;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (accept) begin
				pass_q <= 1'b0;
			end else if (state_q == S_UPD && last) begin
				pass_q <= 1'b1;
			end
			if (state_q == S_PRIME2) begin
				ptr_q <= '0;
			end else if (state_q == S_UPD && !last) begin
				ptr_q <= ptr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rv_q <= '0;
			dt_q <= cmd.dt;
			n_q  <= ring_n;
		end
		if (state_q == S_RD) begin
			rv_q <= rd_clamp;
		end
		if (state_q == S_PRIME1 || state_q == S_PRIME2 || state_q == S_SHIFT) begin
			win_l_q <= win_m_q;
			win_m_q <= win_r_q;
			win_r_q <= pass_q ? stage_rdata : cell_rdata;
		end
		if (state_q == S_SHIFT) begin
			cell_i_q <= cell_rdata;
			k1_q     <= k1_rdata;
		end
		if (state_q == S_TA_W && mul_done) begin
			ta_q <= mul_res;
		end
		if (state_q == S_TD_W && mul_done) begin
			td_q <= mul_res;
		end
		if (state_q == S_SUM) begin
			slope_q <= s_sat;
		end
		if (state_q == S_ST_W && mul_done) begin
			inc_q <= mul_res;
		end
	end

endmodule

/* rtl/core/periodic_advection_diffusion_rk2.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_advection_diffusion_rk2
// Periodic 1-D grid advanced by one Heun step of the centered
// advection-diffusion operator per advance word; write and read words
// access single grid values.
//
//   channel  signals                                   direction  payload
//   item     item_valid / item_ready                   in         cmd, cell_index,
//                                                                 cell_value, step_size
//   result   result_valid / result_ready               out        read_value, saturated
//   config   cfg_we, cfg_index, cfg_data               in         register write
//
// An advance runs the shared 48x16 multiplier three times per value in each of
// its two passes. After reset every grid entry is cleared, one entry a cycle,
// with item_ready low. The result register frees the sequencer, so a stalled
// result_ready only stops the block once a second result is ready.
// ----------------------------------------------------------------------------
module periodic_advection_diffusion_rk2 #(
	parameter int MAX_CELLS  = adrk_pkg::MAX_CELLS_DEF,
	parameter int VALUE_BITS = adrk_pkg::VALUE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [adrk_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [adrk_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  logic [adrk_pkg::CMD_BITS-1:0]       cmd,
	input  logic [adrk_pkg::INDEX_BITS-1:0]     cell_index,
	input  logic signed [adrk_pkg::FIELD_BITS-1:0] cell_value,
	input  logic [adrk_pkg::DT_BITS-1:0]        step_size,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic signed [adrk_pkg::FIELD_BITS-1:0] read_value,
	output logic                                saturated
);

	adrk_pkg::adrk_cfg_t cfg_q;
	adrk_pkg::adrk_cmd_t core_cmd;
	adrk_pkg::adrk_res_t core_res;
	logic                core_res_valid;
	logic                core_res_ready;

	logic                               out_valid_q;
	logic [adrk_pkg::FIELD_BITS-1:0]    read_value_q;
	logic                               saturated_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cell_count <= adrk_pkg::CELL_COUNT_RST;
			cfg_q.adv        <= adrk_pkg::ADV_COEF_RST;
			cfg_q.diff       <= adrk_pkg::DIFF_COEF_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				adrk_pkg::REG_CELL_COUNT:
					cfg_q.cell_count <= cfg_data[adrk_pkg::COUNT_BITS-1:0];
				adrk_pkg::REG_ADV_COEF:
					cfg_q.adv <= cfg_data[adrk_pkg::ADV_BITS-1:0];
				adrk_pkg::REG_DIFF_COEF:
					cfg_q.diff <= cfg_data[adrk_pkg::COEF_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign core_cmd = '{cmd: cmd, index: cell_index, value: cell_value, dt: step_size};

	adrk_core #(
		.MAX_CELLS (MAX_CELLS),
		.VALUE_BITS(VALUE_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd_valid(item_valid),
		.cmd_ready(item_ready),
		.cmd      (core_cmd),
		.res_valid(core_res_valid),
		.res_ready(core_res_ready),
		.res      (core_res)
	);

	// result register
	assign core_res_ready = !out_valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (core_res_valid && core_res_ready) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_res_valid && core_res_ready) begin
			read_value_q <= core_res.read_value;
			saturated_q  <= core_res.saturated;
		end
	end

	assign result_valid = out_valid_q;
	assign read_value   = read_value_q;
	assign saturated    = saturated_q;

endmodule

/* tb/sv/heun_grid_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heun_grid_checker
// Watches the register, item and result ports of the periodic
// advection-diffusion block. Keeps its own copy of the grid, the scratch
// stages and the registers, predicts the result word of every accepted item
// and compares each returned word field by field, oldest prediction first.
// ----------------------------------------------------------------------------
module heun_grid_checker
	import adrk_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic                     item_valid,
	input  logic                     item_ready,
	input  logic [CMD_BITS-1:0]      cmd,
	input  logic [INDEX_BITS-1:0]    cell_index,
	input  logic [FIELD_BITS-1:0]    cell_value,
	input  logic [DT_BITS-1:0]       step_size,
	input  logic                     result_valid,
	input  logic                     result_ready,
	input  logic [FIELD_BITS-1:0]    read_value,
	input  logic                     saturated,
	output int                       mismatches,
	output int                       outstanding
);

	localparam longint VAL_MAX = 64'sd2147483647;
	localparam longint VAL_MIN = -VAL_MAX - 1;

	longint grid_val[MAX_CELLS_DEF];
	longint stage_val[MAX_CELLS_DEF];
	longint slope_k1[MAX_CELLS_DEF];
	logic [COUNT_BITS-1:0] ring_reg;
	longint adv_coef;
	longint diff_coef;
	bit sat_seen;
	int fail_count = 0;
	adrk_res_t pending_q[$];

	assign mismatches = fail_count;

	function automatic longint clip_value(input longint x);
		if (x > VAL_MAX) begin
			sat_seen = 1'b1;
			return VAL_MAX;
		end
		if (x < VAL_MIN) begin
			sat_seen = 1'b1;
			return VAL_MIN;
		end
		return x;
	endfunction

	// floor(a*b / 2^sh), clipped to the value range
	function automatic longint scaled_product(input longint a, input longint b, input int sh);
		logic signed [127:0] wa;
		logic signed [127:0] wb;
		logic signed [127:0] prod;
		wa = a;
		wb = b;
		prod = (wa * wb) >>> sh;
		if (prod > VAL_MAX) begin
			sat_seen = 1'b1;
			return VAL_MAX;
		end
		if (prod < VAL_MIN) begin
			sat_seen = 1'b1;
			return VAL_MIN;
		end
		return prod[63:0];
	endfunction

	// centered advection-diffusion operator at one ring position
	function automatic longint slope_at(input bit from_stage, input int i, input int n);
		int l;
		int r;
		longint vl;
		longint vm;
		longint vr;
		longint ta;
		longint td;
		l = (i == 0) ? n - 1 : i - 1;
		r = (i + 1 == n) ? 0 : i + 1;
		vl = from_stage ? stage_val[l] : grid_val[l];
		vm = from_stage ? stage_val[i] : grid_val[i];
		vr = from_stage ? stage_val[r] : grid_val[r];
		ta = scaled_product(adv_coef, vl - vr, 16);
		td = scaled_product(diff_coef, vr - 2 * vm + vl, 16);
		return clip_value(ta + td);
	endfunction

	function automatic adrk_res_t predict_word(input logic [CMD_BITS-1:0] op,
			input logic [INDEX_BITS-1:0] idx, input logic [FIELD_BITS-1:0] val,
			input logic [DT_BITS-1:0] dt);
		adrk_res_t res;
		int n;
		longint dt_q;
		res.read_value = '0;
		dt_q = longint'({32'd0, dt});
		case (op)
			CMD_WRITE: grid_val[idx] = clip_value(longint'($signed(val)));
			CMD_STEP: begin
				if (ring_reg < MIN_CELLS)
					n = MIN_CELLS;
				else if (ring_reg > MAX_CELLS_DEF)
					n = MAX_CELLS_DEF;
				else
					n = int'(ring_reg);
				for (int i = 0; i < n; i++)
					slope_k1[i] = slope_at(1'b0, i, n);
				for (int i = 0; i < n; i++)
					stage_val[i] = clip_value(grid_val[i] + scaled_product(dt_q, slope_k1[i], 32));
				for (int i = 0; i < n; i++)
					grid_val[i] = clip_value(grid_val[i] +
						scaled_product(dt_q, slope_k1[i] + slope_at(1'b1, i, n), 33));
			end
			CMD_READ: res.read_value = 32'(grid_val[idx]);
			default: ;
		endcase
		res.saturated = sat_seen;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input longint got_v, input longint want_v);
		if (fail_count < 200)
			$display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got_v, want_v);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		adrk_res_t want;
		if (!arst_n) begin
			for (int i = 0; i < MAX_CELLS_DEF; i++) begin
				grid_val[i] = 0;
				stage_val[i] = 0;
				slope_k1[i] = 0;
			end
			ring_reg = CELL_COUNT_RST;
			adv_coef = longint'($signed(ADV_COEF_RST));
			diff_coef = longint'({16'd0, DIFF_COEF_RST});
			sat_seen = 1'b0;
			pending_q.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CELL_COUNT: ring_reg = cfg_data[COUNT_BITS-1:0];
					REG_ADV_COEF:   adv_coef = longint'($signed(cfg_data[ADV_BITS-1:0]));
					REG_DIFF_COEF:  diff_coef = longint'({16'd0, cfg_data[COEF_BITS-1:0]});
					default: ;
				endcase
			end
			if (result_valid && result_ready) begin
				if (pending_q.size() == 0) begin
					report_mismatch("unexpected result word", read_value, 0);
				end else begin
					want = pending_q.pop_front();
					if (read_value !== want.read_value)
						report_mismatch("read_value", read_value, want.read_value);
					if (saturated !== want.saturated)
						report_mismatch("saturated", saturated, want.saturated);
				end
			end
			if (item_valid && item_ready)
				pending_q.push_back(predict_word(cmd, cell_index, cell_value, step_size));
			outstanding <= pending_q.size();
		end
	end

endmodule

/* tb/sv/periodic_advection_diffusion_rk2_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_advection_diffusion_rk2_tb
// Drives write, advance, read and unused words into the advection-diffusion
// block under many register settings, small rings mostly and a few large
// ones, with random gaps on the item side and random stalls on the result
// side. A checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module periodic_advection_diffusion_rk2_tb;
	import adrk_pkg::*;

	localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
	localparam int ITEM_TOTAL = 1150;
	localparam int SETTLE = 16;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0]         cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]        cfg_data = '0;
	logic                            item_valid = 1'b0;
	logic                            item_ready;
	logic [CMD_BITS-1:0]             cmd = '0;
	logic [INDEX_BITS-1:0]           cell_index = '0;
	logic signed [FIELD_BITS-1:0]    cell_value = '0;
	logic [DT_BITS-1:0]              step_size = '0;
	logic                            result_valid;
	logic                            result_ready = 1'b0;
	logic signed [FIELD_BITS-1:0]    read_value;
	logic                            saturated;

	int mismatches;
	int outstanding;
	bit no_gaps = 1'b0;
	int ready_hold = 0;
	int sent = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	periodic_advection_diffusion_rk2 u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.cmd          (cmd),
		.cell_index   (cell_index),
		.cell_value   (cell_value),
		.step_size    (step_size),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.read_value   (read_value),
		.saturated    (saturated)
	);

	heun_grid_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.cmd          (cmd),
		.cell_index   (cell_index),
		.cell_value   (cell_value),
		.step_size    (step_size),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.read_value   (read_value),
		.saturated    (saturated),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 4);
		return $urandom_range(12, 70);
	endfunction

	function automatic logic [FIELD_BITS-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0;
			3, 4, 5: return $urandom;
			default: return 32'($urandom_range(0, 32'h01FF_FFFF)) - 32'h0100_0000;
		endcase
	endfunction

	function automatic logic [DT_BITS-1:0] pick_dt();
		case ($urandom_range(0, 9))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom;
			default: return $urandom_range(0, 32'h00FF_FFFF);
		endcase
	endfunction

	function automatic logic [ADV_BITS-1:0] pick_adv();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0;
			3: return $urandom;
			default: return 32'($urandom_range(0, 32'h0080_0000)) - 32'h0040_0000;
		endcase
	endfunction

	function automatic logic [COEF_BITS-1:0] pick_diff();
		case ($urandom_range(0, 7))
			0: return 48'h0;
			1: return 48'hFFFF_FFFF_FFFF;
			2: return {16'($urandom), $urandom};
			default: return 48'($urandom_range(0, 32'h0010_0000));
		endcase
	endfunction

	// result side: random stalls, no new ones while no_gaps is set
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			ready_hold <= 0;
		end else if (ready_hold != 0) begin
			result_ready <= 1'b0;
			ready_hold <= ready_hold - 1;
		end else if (!no_gaps && $urandom_range(0, 4) == 0) begin
			result_ready <= 1'b0;
			ready_hold <= pick_gap();
		end else begin
			result_ready <= 1'b1;
		end
	end

	task automatic send_word(input logic [CMD_BITS-1:0] op, input logic [INDEX_BITS-1:0] idx,
			input logic [FIELD_BITS-1:0] val, input logic [DT_BITS-1:0] dt);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		cmd <= op;
		cell_index <= idx;
		cell_value <= val;
		step_size <= dt;
		do @(posedge clk); while (!(item_valid && item_ready));
		sent++;
	endtask

	task automatic drain_results();
		item_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_settings(input logic [COUNT_BITS-1:0] count,
			input logic [ADV_BITS-1:0] adv, input logic [COEF_BITS-1:0] diff);
		logic [CFG_DATA_BITS-1:0] junk;
		junk = {16'($urandom), $urandom};
		cfg_we <= 1'b1;
		cfg_index <= REG_CELL_COUNT;
		cfg_data <= {junk[CFG_DATA_BITS-1:COUNT_BITS], count};
		@(posedge clk);
		cfg_index <= REG_ADV_COEF;
		cfg_data <= {junk[CFG_DATA_BITS-1:ADV_BITS], adv};
		@(posedge clk);
		cfg_index <= REG_DIFF_COEF;
		cfg_data <= diff;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		int n;
		int r;
		int steps_left;
		int big_phases;
		bit big;
		logic [COUNT_BITS-1:0] count;
		big_phases = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset contents, extremes, unused command, zero and full steps
		send_word(CMD_READ, 8'd0, 32'h0, 32'h0);
		send_word(CMD_READ, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(CMD_WRITE, 8'd0, 32'h7FFF_FFFF, 32'h0);
		send_word(CMD_WRITE, 8'd255, 32'h8000_0000, 32'h0);
		send_word(CMD_WRITE, 8'd128, 32'h1234_5678, 32'hFFFF_FFFF);
		send_word(CMD_READ, 8'd0, 32'h0, 32'h0);
		send_word(CMD_READ, 8'd255, 32'h0, 32'h0);
		send_word(CMD_UNUSED, 8'hAA, 32'h5555_AAAA, 32'hFFFF_0000);
		send_word(CMD_STEP, 8'd0, 32'h0, 32'h0);
		send_word(CMD_READ, 8'd128, 32'h0, 32'h0);
		send_word(CMD_STEP, 8'd0, 32'h0, 32'hFFFF_FFFF);
		send_word(CMD_READ, 8'd0, 32'h0, 32'h0);

		// count below the minimum, cell outside the ring
		drain_results();
		write_settings(9'd0, 32'h8000_0000, 48'h0);
		send_word(CMD_WRITE, 8'd0, 32'h3FFF_FFFF, 32'h0);
		send_word(CMD_WRITE, 8'd1, 32'hC000_0000, 32'h0);
		send_word(CMD_WRITE, 8'd2, 32'h0000_0001, 32'h0);
		send_word(CMD_WRITE, 8'd200, 32'h7FFF_FFFF, 32'h0);
		send_word(CMD_STEP, 8'd0, 32'h0, 32'h8000_0000);
		send_word(CMD_READ, 8'd1, 32'h0, 32'h0);
		send_word(CMD_READ, 8'd200, 32'h0, 32'h0);

		// count above the maximum, largest coefficients
		drain_results();
		write_settings(9'd511, 32'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF);
		send_word(CMD_STEP, 8'd0, 32'h0, 32'h0000_1000);
		send_word(CMD_READ, 8'd5, 32'h0, 32'h0);

		while (sent < ITEM_TOTAL) begin
			drain_results();
			big = (big_phases < 4) && ($urandom_range(0, 7) == 0);
			if (big) begin
				big_phases++;
				case ($urandom_range(0, 4))
					0: count = 9'd255;
					1: count = 9'd256;
					2: count = 9'd257;
					3: count = 9'd511;
					default: count = COUNT_BITS'($urandom_range(128, 511));
				endcase
			end else begin
				case ($urandom_range(0, 5))
					0: count = 9'd0;
					1: count = 9'd1;
					2: count = 9'd2;
					3: count = 9'd3;
					default: count = COUNT_BITS'($urandom_range(4, 16));
				endcase
			end
			write_settings(count, pick_adv(), pick_diff());
			no_gaps = ($urandom_range(0, 3) == 0);
			n = (count < MIN_CELLS) ? MIN_CELLS : (count > MAX_CELLS_DEF) ? MAX_CELLS_DEF : count;

			// load the ring, then mix advances, reads and stray words
			if (big) begin
				repeat (12) send_word(CMD_WRITE, INDEX_BITS'($urandom), pick_value(), $urandom);
			end else begin
				for (int i = 0; i < n; i++)
					if ($urandom_range(0, 3) != 0)
						send_word(CMD_WRITE, INDEX_BITS'(i), pick_value(), $urandom);
			end
			steps_left = big ? 2 : 12;
			repeat (big ? 10 : 30) begin
				r = $urandom_range(0, 9);
				if (r < 3 && steps_left > 0) begin
					send_word(CMD_STEP, INDEX_BITS'($urandom), $urandom, pick_dt());
					steps_left--;
				end else if (r < 6) begin
					send_word(CMD_READ, INDEX_BITS'($urandom_range(0, n - 1)), $urandom,
						$urandom);
				end else if (r < 7) begin
					send_word(CMD_READ, INDEX_BITS'($urandom), $urandom, $urandom);
				end else if (r < 9) begin
					send_word(CMD_WRITE,
						INDEX_BITS'((r == 7) ? $urandom_range(0, n - 1) : $urandom),
						pick_value(), $urandom);
				end else begin
					send_word(CMD_UNUSED, INDEX_BITS'($urandom), $urandom, $urandom);
				end
				if ($urandom_range(0, 49) == 0)
					drain_results();
			end
		end

		drain_results();
		repeat (64) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
